// ===== src/hbd_pkg.sv =====
// Shared types and codes for the headroom byte deque.
// No dependencies; imported by every module of the block.
package hbd_pkg;

   localparam int ACTION_W = 4;
   localparam int BYTE_W   = 8;
   localparam int POS_W    = 8;
   localparam int FIELD_W  = 9;
   localparam int ERR_W    = 2;

   localparam logic [ACTION_W-1:0] ACT_SET        = 4'd0;
   localparam logic [ACTION_W-1:0] ACT_CLEAR      = 4'd1;
   localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 4'd2;
   localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 4'd3;
   localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 4'd4;
   localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 4'd5;
   localparam logic [ACTION_W-1:0] ACT_READ       = 4'd6;
   localparam logic [ACTION_W-1:0] ACT_WRITE      = 4'd7;
   localparam logic [ACTION_W-1:0] ACT_GROW_BACK  = 4'd8;
   localparam logic [ACTION_W-1:0] ACT_GROW_FRONT = 4'd9;
   localparam logic [ACTION_W-1:0] ACT_STATUS     = 4'd10;

   localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
   localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

   // store access and outcome of one action
   typedef struct packed {
      logic             wr_en;
      logic             rd_en;
      logic [ERR_W-1:0] error;
   } hbd_op_type;

endpackage

// ===== src/hbd_store.sv =====
// Byte store: single port memory with registered read data.
// Depends on hbd_pkg for the operation struct.
module hbd_store import hbd_pkg::*; #(
   parameter int DEPTH = 256,
   parameter int IW    = 8
) (
   input  logic              clock,
   input  hbd_op_type        op,
   input  logic [IW-1:0]     addr,
   input  logic [BYTE_W-1:0] wdata,
   output logic [BYTE_W-1:0] rdata
);

   logic [BYTE_W-1:0] mem_ff [DEPTH];
   logic [BYTE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (op.wr_en) begin
         mem_ff[addr] <= wdata;
      end
      if (op.rd_en) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/hbd_window.sv =====
// Window bookkeeping: offset and fill registers, action decode, range checks
// and store address. Depends on hbd_pkg for codes and the operation struct.
module hbd_window import hbd_pkg::*; #(
   parameter int BLOCK_BYTES = 256,
   parameter int AW          = 9,
   parameter int IW          = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                act_valid,
   input  logic [ACTION_W-1:0] action,
   input  logic [POS_W-1:0]    position,
   input  logic [FIELD_W-1:0]  amount,
   input  logic [FIELD_W-1:0]  length,
   output hbd_op_type          op,
   output logic [IW-1:0]       mem_addr,
   output logic [FIELD_W-1:0]  win_offset,
   output logic [FIELD_W-1:0]  win_length,
   output logic [FIELD_W-1:0]  win_room
);

   // compare width: covers every sum of offset, fill and a 9-bit field
   localparam int CW = ((AW > FIELD_W) ? AW : FIELD_W) + 1;

   logic [AW-1:0] start_ff, start_in;
   logic [AW-1:0] fill_ff, fill_in;
   logic [CW-1:0] start_x, fill_x, amt_x, len_x, pos_x, end_x, block_x, addr_x;
   logic [CW-1:0] room_x;
   logic [CW-1:0] start_nx, fill_nx;
   logic          wr, rd;
   logic [ERR_W-1:0] err;

   assign start_x = CW'(start_ff);
   assign fill_x  = CW'(fill_ff);
   assign amt_x   = CW'(amount);
   assign len_x   = CW'(length);
   assign pos_x   = CW'(position);
   assign end_x   = start_x + fill_x;
   assign block_x = CW'(BLOCK_BYTES);

   always_comb begin
      start_in = start_ff;
      fill_in  = fill_ff;
      err      = ERR_OK;
      wr       = 1'b0;
      rd       = 1'b0;
      addr_x   = end_x;
      case (action)
         ACT_SET: begin
            if (amt_x + len_x <= block_x) begin
               start_in = AW'(amt_x);
               fill_in  = AW'(len_x);
            end else begin
               err = ERR_RANGE;
            end
         end
         ACT_CLEAR: begin
            fill_in = '0;
         end
         ACT_PUSH_BACK: begin
            if (end_x + CW'(1) <= block_x) begin
               wr      = 1'b1;
               addr_x  = end_x;
               fill_in = fill_ff + AW'(1);
            end else begin
               err = ERR_RANGE;
            end
         end
         ACT_PUSH_FRONT: begin
            if (start_ff != '0) begin
               wr       = 1'b1;
               addr_x   = start_x - CW'(1);
               start_in = start_ff - AW'(1);
               fill_in  = fill_ff + AW'(1);
            end else begin
               err = ERR_RANGE;
            end
         end
         ACT_POP_BACK: begin
            if (fill_ff == '0) begin
               err = ERR_EMPTY;
            end else begin
               rd      = 1'b1;
               addr_x  = end_x - CW'(1);
               fill_in = fill_ff - AW'(1);
            end
         end
         ACT_POP_FRONT: begin
            if (fill_ff == '0) begin
               err = ERR_EMPTY;
            end else begin
               rd       = 1'b1;
               addr_x   = start_x;
               start_in = start_ff + AW'(1);
               fill_in  = fill_ff - AW'(1);
            end
         end
         ACT_READ: begin
            if (pos_x >= fill_x) begin
               err = ERR_EMPTY;
            end else begin
               rd     = 1'b1;
               addr_x = start_x + pos_x;
            end
         end
         ACT_WRITE: begin
            if (pos_x >= fill_x) begin
               err = ERR_EMPTY;
            end else begin
               wr     = 1'b1;
               addr_x = start_x + pos_x;
            end
         end
         ACT_GROW_BACK: begin
            if (end_x + amt_x <= block_x) begin
               fill_in = AW'(fill_x + amt_x);
            end else begin
               err = ERR_RANGE;
            end
         end
         ACT_GROW_FRONT: begin
            if (amt_x <= start_x) begin
               start_in = AW'(start_x - amt_x);
               fill_in  = AW'(fill_x + amt_x);
            end else begin
               err = ERR_RANGE;
            end
         end
         default: begin
            // status and unused codes report the window unchanged
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         fill_ff  <= '0;
      end else if (act_valid) begin
         start_ff <= start_in;
         fill_ff  <= fill_in;
      end
   end

   assign start_nx = CW'(start_in);
   assign fill_nx  = CW'(fill_in);
   assign room_x   = block_x - start_nx - fill_nx;

   assign op.wr_en    = act_valid & wr;
   assign op.rd_en    = act_valid & rd;
   assign op.error    = err;
   assign mem_addr    = addr_x[IW-1:0];
   assign win_offset  = start_nx[FIELD_W-1:0];
   assign win_length  = fill_nx[FIELD_W-1:0];
   assign win_room    = room_x[FIELD_W-1:0];

endmodule

// ===== src/headroom_byte_deque.sv =====
// Headroom byte deque: a byte store holding one data window, one action per beat.
// A result strobes once its beat has passed the input register, then window
// logic and store read into the result registers.
// Throughput: one beat every cycle; busy stays low, set by the single store port.
// Reset clears the window to offset 0, length 0; store contents are not cleared.
// Depends on hbd_pkg, hbd_window and hbd_store.
module headroom_byte_deque import hbd_pkg::*; #(
   parameter int BLOCK_BYTES = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [BYTE_W-1:0]   req_byte_in,
   input  logic [POS_W-1:0]    req_position,
   input  logic [FIELD_W-1:0]  req_amount,
   input  logic [FIELD_W-1:0]  req_length,
   output logic                rsp_strobe,
   output logic [BYTE_W-1:0]   rsp_byte_out,
   output logic [FIELD_W-1:0]  rsp_window_offset,
   output logic [FIELD_W-1:0]  rsp_window_length,
   output logic [FIELD_W-1:0]  rsp_back_room,
   output logic [ERR_W-1:0]    rsp_error
);

   localparam int AW = $clog2(BLOCK_BYTES + 1);
   localparam int IW = $clog2(BLOCK_BYTES);

   // input register
   logic                valid_ff;
   logic [ACTION_W-1:0] action_ff;
   logic [BYTE_W-1:0]   byte_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [FIELD_W-1:0]  amount_ff;
   logic [FIELD_W-1:0]  length_ff;

   // result register
   logic                strobe_ff;
   logic                rd_ff;
   logic [FIELD_W-1:0]  offset_ff;
   logic [FIELD_W-1:0]  wlen_ff;
   logic [FIELD_W-1:0]  room_ff;
   logic [ERR_W-1:0]    error_ff;

   hbd_op_type          op;
   logic [IW-1:0]       mem_addr;
   logic [BYTE_W-1:0]   rdata;
   logic [FIELD_W-1:0]  win_offset, win_length, win_room;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         valid_ff  <= start & ~busy;
         strobe_ff <= valid_ff;
      end
      action_ff <= req_action;
      byte_ff   <= req_byte_in;
      pos_ff    <= req_position;
      amount_ff <= req_amount;
      length_ff <= req_length;
      rd_ff     <= op.rd_en;
      offset_ff <= win_offset;
      wlen_ff   <= win_length;
      room_ff   <= win_room;
      error_ff  <= op.error;
   end

   hbd_window #(
      .BLOCK_BYTES (BLOCK_BYTES),
      .AW          (AW),
      .IW          (IW)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .act_valid  (valid_ff),
      .action     (action_ff),
      .position   (pos_ff),
      .amount     (amount_ff),
      .length     (length_ff),
      .op         (op),
      .mem_addr   (mem_addr),
      .win_offset (win_offset),
      .win_length (win_length),
      .win_room   (win_room)
   );

   hbd_store #(
      .DEPTH (BLOCK_BYTES),
      .IW    (IW)
   ) u_store (
      .clock (clock),
      .op    (op),
      .addr  (mem_addr),
      .wdata (byte_ff),
      .rdata (rdata)
   );

   assign rsp_strobe        = strobe_ff;
   assign rsp_byte_out      = rd_ff ? rdata : '0;
   assign rsp_window_offset = offset_ff;
   assign rsp_window_length = wlen_ff;
   assign rsp_back_room     = room_ff;
   assign rsp_error         = error_ff;

   // every beat taken gives exactly one result, through the input and result registers
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("beat taken without a result");

   a_no_stray_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result without a beat");

   // offset, length and room always add up to the store size
   a_room_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (FIELD_W'(rsp_window_offset + rsp_window_length + rsp_back_room)
                      == FIELD_W'(BLOCK_BYTES)))
      else $error("back room inconsistent with window");

   a_err_no_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_error != ERR_OK) |-> rsp_byte_out == '0)
      else $error("byte returned on a failed action");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for headroom_byte_deque: directed window and store cases, then random traffic.
// Uses a behavioural shadow of the window and store; depends on hbd_pkg and the block's RTL.
module tb;
   import hbd_pkg::*;

   localparam int STORE_BYTES  = 256;
   localparam int RANDOM_BEATS = 1900;
   localparam int DRAIN_CYCLES = 8;
   localparam int QUIET_LIMIT  = 500;
   localparam int PRINT_LIMIT  = 40;

   // codes past ACT_STATUS behave as status
   localparam logic [ACTION_W-1:0] ACT_UNKNOWN_LO = 4'd11;
   localparam logic [ACTION_W-1:0] ACT_UNKNOWN_HI = 4'd15;

   typedef struct packed {
      logic [BYTE_W-1:0]  byte_out;
      logic [FIELD_W-1:0] win_offset;
      logic [FIELD_W-1:0] win_length;
      logic [FIELD_W-1:0] back_room;
      logic [ERR_W-1:0]   error;
   } window_result_type;

   logic                clock;
   logic                reset        = 1'b1;
   logic                start        = 1'b0;
   logic                busy;
   logic [ACTION_W-1:0] req_action   = '0;
   logic [BYTE_W-1:0]   req_byte_in  = '0;
   logic [POS_W-1:0]    req_position = '0;
   logic [FIELD_W-1:0]  req_amount   = '0;
   logic [FIELD_W-1:0]  req_length   = '0;
   logic                rsp_strobe;
   logic [BYTE_W-1:0]   rsp_byte_out;
   logic [FIELD_W-1:0]  rsp_window_offset;
   logic [FIELD_W-1:0]  rsp_window_length;
   logic [FIELD_W-1:0]  rsp_back_room;
   logic [ERR_W-1:0]    rsp_error;

   // shadow of the block
   logic [BYTE_W-1:0] shadow_bytes [STORE_BYTES];
   bit                byte_written [STORE_BYTES];
   int                win_start = 0;
   int                win_fill  = 0;

   window_result_type window_results_due [$];
   int beats_sent      = 0;
   int results_checked = 0;
   int mismatches      = 0;
   int range_errors    = 0;
   int empty_errors    = 0;
   int quiet_cycles    = 0;

   headroom_byte_deque #(.BLOCK_BYTES(STORE_BYTES)) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_byte_in       (req_byte_in),
      .req_position      (req_position),
      .req_amount        (req_amount),
      .req_length        (req_length),
      .rsp_strobe        (rsp_strobe),
      .rsp_byte_out      (rsp_byte_out),
      .rsp_window_offset (rsp_window_offset),
      .rsp_window_length (rsp_window_length),
      .rsp_back_room     (rsp_back_room),
      .rsp_error         (rsp_error)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void put_byte(input int idx, input logic [BYTE_W-1:0] data);
      shadow_bytes[idx] = data;
      byte_written[idx] = 1'b1;
   endfunction

   // applies one action to the shadow window and returns the result it gives
   function automatic window_result_type predict_window(input logic [ACTION_W-1:0] act,
                                                         input logic [BYTE_W-1:0] data,
                                                         input logic [POS_W-1:0] pos,
                                                         input logic [FIELD_W-1:0] amt,
                                                         input logic [FIELD_W-1:0] len);
      window_result_type r;
      r = '0;
      r.error = ERR_OK;
      case (act)
         ACT_SET: begin
            if (int'(amt) + int'(len) <= STORE_BYTES) begin
               win_start = int'(amt);
               win_fill  = int'(len);
            end else r.error = ERR_RANGE;
         end
         ACT_CLEAR: win_fill = 0;
         ACT_PUSH_BACK: begin
            if (win_start + win_fill + 1 <= STORE_BYTES) begin
               put_byte(win_start + win_fill, data);
               win_fill++;
            end else r.error = ERR_RANGE;
         end
         ACT_PUSH_FRONT: begin
            if (win_start >= 1) begin
               win_start--;
               win_fill++;
               put_byte(win_start, data);
            end else r.error = ERR_RANGE;
         end
         ACT_POP_BACK: begin
            if (win_fill == 0) r.error = ERR_EMPTY;
            else begin
               r.byte_out = shadow_bytes[win_start + win_fill - 1];
               win_fill--;
            end
         end
         ACT_POP_FRONT: begin
            if (win_fill == 0) r.error = ERR_EMPTY;
            else begin
               r.byte_out = shadow_bytes[win_start];
               win_start++;
               win_fill--;
            end
         end
         ACT_READ: begin
            if (int'(pos) >= win_fill) r.error = ERR_EMPTY;
            else r.byte_out = shadow_bytes[win_start + int'(pos)];
         end
         ACT_WRITE: begin
            if (int'(pos) >= win_fill) r.error = ERR_EMPTY;
            else put_byte(win_start + int'(pos), data);
         end
         ACT_GROW_BACK: begin
            if (win_start + win_fill + int'(amt) <= STORE_BYTES) win_fill += int'(amt);
            else r.error = ERR_RANGE;
         end
         ACT_GROW_FRONT: begin
            if (int'(amt) <= win_start) begin
               win_start -= int'(amt);
               win_fill  += int'(amt);
            end else r.error = ERR_RANGE;
         end
         default: ;
      endcase
      r.win_offset = FIELD_W'(win_start);
      r.win_length = FIELD_W'(win_fill);
      r.back_room  = FIELD_W'(STORE_BYTES - win_start - win_fill);
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("ERROR at %0t ns: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [FIELD_W-1:0] got,
                              input logic [FIELD_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s: got %h, want %h",
                                   results_checked, name, got, want));
   endtask

   // start stays high from one beat to the next; only a gap lowers it
   task automatic send_action(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] data,
                              input logic [POS_W-1:0] pos, input logic [FIELD_W-1:0] amt,
                              input logic [FIELD_W-1:0] len);
      window_result_type due;
      req_action   <= act;
      req_byte_in  <= data;
      req_position <= pos;
      req_amount   <= amt;
      req_length   <= len;
      start        <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      due = predict_window(act, data, pos, amt, len);
      window_results_due.push_back(due);
      beats_sent++;
      if (due.error == ERR_RANGE) range_errors++;
      if (due.error == ERR_EMPTY) empty_errors++;
   endtask

   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic send_random_action();
      logic [ACTION_W-1:0] act;
      logic [BYTE_W-1:0]   data;
      logic [POS_W-1:0]    pos;
      logic [FIELD_W-1:0]  amt;
      logic [FIELD_W-1:0]  len;
      int pick;
      int span;
      data = BYTE_W'($urandom_range(0, 255));
      pos  = POS_W'($urandom_range(0, 255));
      amt  = FIELD_W'($urandom_range(0, 511));
      len  = FIELD_W'($urandom_range(0, 511));
      pick = $urandom_range(0, 99);
      if (pick < 10) act = ACTION_W'($urandom_range(0, 15));
      else begin
         pick = $urandom_range(0, 99);
         if      (pick < 5)  act = ACT_SET;
         else if (pick < 8)  act = ACT_CLEAR;
         else if (pick < 23) act = ACT_PUSH_BACK;
         else if (pick < 35) act = ACT_PUSH_FRONT;
         else if (pick < 47) act = ACT_POP_BACK;
         else if (pick < 59) act = ACT_POP_FRONT;
         else if (pick < 71) act = ACT_READ;
         else if (pick < 83) act = ACT_WRITE;
         else if (pick < 90) act = ACT_GROW_BACK;
         else if (pick < 96) act = ACT_GROW_FRONT;
         else                act = ACT_STATUS;
         // mostly legal windows, short grows and in-range indexes
         if (act == ACT_SET && $urandom_range(0, 4) != 0) begin
            amt  = FIELD_W'($urandom_range(0, STORE_BYTES));
            span = STORE_BYTES - int'(amt);
            len  = FIELD_W'($urandom_range(0, span < 24 ? span : 24));
         end
         if ((act == ACT_GROW_BACK || act == ACT_GROW_FRONT) && $urandom_range(0, 4) != 0)
            amt = FIELD_W'($urandom_range(0, 10));
         if ((act == ACT_READ || act == ACT_WRITE) && win_fill > 0 && $urandom_range(0, 4) != 0)
            pos = POS_W'($urandom_range(0, win_fill - 1));
      end
      // a read of a never-written entry becomes a write of that entry
      case (act)
         ACT_POP_BACK:
            if (win_fill > 0 && !byte_written[win_start + win_fill - 1]) begin
               act = ACT_WRITE;
               pos = POS_W'(win_fill - 1);
            end
         ACT_POP_FRONT:
            if (win_fill > 0 && !byte_written[win_start]) begin
               act = ACT_WRITE;
               pos = '0;
            end
         ACT_READ:
            if (int'(pos) < win_fill && !byte_written[win_start + int'(pos)]) act = ACT_WRITE;
         default: ;
      endcase
      send_action(act, data, pos, amt, len);
   endtask

   task automatic test_reset_window();
      send_action(ACT_STATUS, 8'h00, 8'h00, 9'd0, 9'd0);
      send_action(ACT_POP_BACK, 8'h00, 8'h00, 9'd0, 9'd0);
      send_action(ACT_POP_FRONT, 8'h00, 8'h00, 9'd0, 9'd0);
      send_action(ACT_READ, 8'h00, 8'h00, 9'd0, 9'd0);
      send_action(ACT_PUSH_FRONT, 8'h11, 8'h00, 9'd0, 9'd0);
   endtask

   task automatic test_window_limits();
      send_action(ACT_SET, 8'h00, 8'h00, 9'd511, 9'd511);
      send_action(ACT_SET, 8'h00, 8'h00, 9'd1, 9'd256);
      send_action(ACT_SET, 8'h00, 8'h00, 9'd256, 9'd0);
      send_action(ACT_PUSH_BACK, 8'h22, 8'h00, 9'd0, 9'd0);
      send_action(ACT_SET, 8'h00, 8'h00, 9'd0, 9'd256);
      send_action(ACT_CLEAR, 8'h00, 8'h00, 9'd0, 9'd0);
   endtask

   task automatic test_end_access();
      send_action(ACT_SET, 8'h00, 8'h00, 9'd128, 9'd0);
      send_action(ACT_PUSH_BACK, 8'hFF, 8'h00, 9'd0, 9'd0);
      send_action(ACT_PUSH_FRONT, 8'h00, 8'h00, 9'd0, 9'd0);
      send_action(ACT_PUSH_BACK, 8'hA5, 8'h00, 9'd0, 9'd0);
      send_action(ACT_POP_FRONT, 8'h00, 8'h00, 9'd0, 9'd0);
      send_action(ACT_POP_BACK, 8'h00, 8'h00, 9'd0, 9'd0);
   endtask

   task automatic test_indexed_access();
      send_action(ACT_WRITE, 8'h5A, 8'h00, 9'd0, 9'd0);
      send_action(ACT_READ, 8'h00, 8'h00, 9'd0, 9'd0);
      send_action(ACT_READ, 8'h00, 8'h01, 9'd0, 9'd0);
      send_action(ACT_WRITE, 8'h77, 8'hFF, 9'd0, 9'd0);
   endtask

   task automatic test_grow();
      send_action(ACT_GROW_BACK, 8'h00, 8'h00, 9'd0, 9'd0);
      send_action(ACT_GROW_FRONT, 8'h00, 8'h00, 9'd129, 9'd0);
      send_action(ACT_GROW_BACK, 8'h00, 8'h00, 9'd511, 9'd0);
      send_action(ACT_GROW_FRONT, 8'h00, 8'h00, 9'd128, 9'd0);
      send_action(ACT_GROW_BACK, 8'h00, 8'h00, 9'd127, 9'd0);
      // window now spans the whole store
      send_action(ACT_PUSH_BACK, 8'h33, 8'h00, 9'd0, 9'd0);
      send_action(ACT_WRITE, 8'hC3, 8'hFF, 9'd0, 9'd0);
      send_action(ACT_READ, 8'h00, 8'hFF, 9'd0, 9'd0);
   endtask

   task automatic test_unknown_actions();
      send_action(ACT_UNKNOWN_LO, 8'hFF, 8'hFF, 9'd511, 9'd511);
      send_action(ACT_UNKNOWN_HI, 8'h00, 8'h00, 9'd0, 9'd0);
   endtask

   task automatic test_random_traffic();
      int burst;
      int sent;
      sent = 0;
      while (sent < RANDOM_BEATS) begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            send_random_action();
            sent++;
         end
         // a quarter of bursts run straight on into the next one
         hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
      end
   endtask

   always @(posedge clock) begin : result_check
      window_result_type due;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (window_results_due.size() == 0)
            report_mismatch("result beat with nothing expected");
         else begin
            due = window_results_due.pop_front();
            check_field("byte_out", FIELD_W'(rsp_byte_out), FIELD_W'(due.byte_out));
            check_field("window_offset", rsp_window_offset, due.win_offset);
            check_field("window_length", rsp_window_length, due.win_length);
            check_field("back_room", rsp_back_room, due.back_room);
            check_field("error", FIELD_W'(rsp_error), FIELD_W'(due.error));
         end
         results_checked++;
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe === 1'b1) quiet_cycles <= 0;
      else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
         $display("headroom_byte_deque: mismatch");
         $finish;
      end else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_window();
      hold_off(2);
      test_window_limits();
      test_end_access();
      hold_off(1);
      test_indexed_access();
      test_grow();
      hold_off(3);
      test_unknown_actions();
      test_random_traffic();
      start <= 1'b0;
      while (window_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d actions sent, %0d results checked, %0d mismatching fields",
               beats_sent, results_checked, mismatches);
      $display("window edge cases hit: %0d out-of-store, %0d empty or past-length",
               range_errors, empty_errors);
      if (mismatches == 0) $display("headroom_byte_deque: match");
      else $display("headroom_byte_deque: mismatch");
      $finish;
   end

endmodule
